FILE: rtl/assert_macros.svh
// Assertion macros for the checker of the stack engine.
// Depends on nothing; each macro takes a label, a clock, a reset, a property or expression and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define CHK_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);

`endif

FILE: rtl/lse_pkg.sv
// Package for the stack engine: beat types, request codes, controller states and commands.
// Depends on nothing; used by every module of the block.
package lse_pkg;

  localparam int DEPTH = 16;
  localparam int CAP_W = 5;
  localparam int PTR_W = 5;
  localparam int IDX_W = 4;
  localparam int WORD_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  localparam logic [2:0] REQ_PUSH = 3'd0;
  localparam logic [2:0] REQ_POP  = 3'd1;
  localparam logic [2:0] REQ_POPB = 3'd2;
  localparam logic [2:0] REQ_FIND = 3'd3;
  localparam logic [2:0] REQ_MOVE = 3'd4;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] data_out;
    logic [IDX_W-1:0]         position;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_SCAN
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_PUSH,
    CMD_POP,
    CMD_GRAB,
    CMD_SHIFT,
    CMD_FIN_POPB,
    CMD_FIN_MOVE,
    CMD_NEXT,
    CMD_FOUND,
    CMD_FAIL
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       occ_zero;
    logic       full;
    logic       idx_ok;
    logic       scan_end;
    logic       match;
  } status_t;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CAP_W'(1);
    end else if (v > CAP_W'(DEPTH)) begin
      r = CAP_W'(DEPTH);
    end
    return r;
  endfunction

endpackage

FILE: rtl/lse_ctrl.sv
// Controller of the stack engine: sequences each request through decode, shift and scan steps.
// Depends on lse_pkg; drives commands into lse_dp and reads its status.
module lse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lse_pkg::status_t status,
  output lse_pkg::cmd_t    cmd,
  output logic             busy
);
  import lse_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd        = CMD_ACCEPT;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (status.req_type)
          REQ_PUSH: cmd = status.full ? CMD_FAIL : CMD_PUSH;
          REQ_POP:  cmd = status.occ_zero ? CMD_FAIL : CMD_POP;
          REQ_POPB: begin
            if (status.occ_zero) begin
              cmd = CMD_FAIL;
            end else begin
              cmd        = CMD_GRAB;
              state_next = ST_SHIFT;
            end
          end
          REQ_FIND: state_next = ST_SCAN;
          REQ_MOVE: begin
            if (status.idx_ok) begin
              cmd        = CMD_GRAB;
              state_next = ST_SHIFT;
            end else begin
              cmd = CMD_FAIL;
            end
          end
          default: cmd = CMD_FAIL;
        endcase
      end
      ST_SHIFT: begin
        if (!status.scan_end) begin
          cmd = CMD_SHIFT;
        end else begin
          cmd        = (status.req_type == REQ_POPB) ? CMD_FIN_POPB : CMD_FIN_MOVE;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_end) begin
          cmd        = CMD_FAIL;
          state_next = ST_IDLE;
        end else if (status.match) begin
          cmd        = CMD_FOUND;
          state_next = ST_IDLE;
        end else begin
          cmd = CMD_NEXT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/lse_dp.sv
// Datapath of the stack engine: entry store, pointer, held word, occupancy, capacity and result.
// Depends on lse_pkg; carries out the commands issued by lse_ctrl.
module lse_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lse_pkg::cmd_t              cmd,
  input  lse_pkg::req_t              req,
  input  logic                       cfg_we,
  input  logic [lse_pkg::CAP_W-1:0]  cfg_data,
  output lse_pkg::status_t           status,
  output logic                       done,
  output lse_pkg::rsp_t              rsp
);
  import lse_pkg::*;

  logic [WORD_W-1:0] entries [DEPTH];
  logic [WORD_W-1:0] hold;
  logic [PTR_W-1:0]  ptr;
  logic [CAP_W-1:0]  occ;
  logic [CAP_W-1:0]  occ_next;
  logic [CAP_W-1:0]  occ_m1;
  logic [CAP_W-1:0]  cap;
  req_t              cur;
  rsp_t              rsp_next;
  logic              fin;
  logic [WORD_W-1:0] rd_word;
  logic [PTR_W-1:0]  ptr_m1;

  assign occ_m1  = occ - CAP_W'(1);
  assign ptr_m1  = ptr - PTR_W'(1);
  assign rd_word = entries[ptr[IDX_W-1:0]];

  assign status.req_type = cur.req_type;
  assign status.occ_zero = (occ == '0);
  assign status.full     = (occ >= cap);
  assign status.idx_ok   = (CAP_W'(cur.index) < occ);
  assign status.scan_end = (PTR_W'(occ) <= ptr);
  assign status.match    = (rd_word == cur.value);

  always_comb begin
    occ_next = occ;
    fin      = 1'b0;
    rsp_next = '0;
    case (cmd)
      CMD_PUSH: begin
        occ_next          = occ + CAP_W'(1);
        fin               = 1'b1;
        rsp_next.ok       = 1'b1;
        rsp_next.position = occ[IDX_W-1:0];
      end
      CMD_POP: begin
        occ_next          = occ_m1;
        fin               = 1'b1;
        rsp_next.ok       = 1'b1;
        rsp_next.data_out = rd_word;
      end
      CMD_FIN_POPB: begin
        occ_next          = occ_m1;
        fin               = 1'b1;
        rsp_next.ok       = 1'b1;
        rsp_next.data_out = hold;
      end
      CMD_FIN_MOVE: begin
        fin               = 1'b1;
        rsp_next.ok       = 1'b1;
        rsp_next.position = occ_m1[IDX_W-1:0];
      end
      CMD_FOUND: begin
        fin               = 1'b1;
        rsp_next.ok       = 1'b1;
        rsp_next.position = ptr[IDX_W-1:0];
      end
      CMD_FAIL: fin = 1'b1;
      default: ;
    endcase
    if (cfg_we) begin
      occ_next = '0;
    end
    rsp_next.is_empty = (occ_next == '0);
    rsp_next.is_full  = (occ_next >= cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      cap  <= CAP_RESET;
      done <= 1'b0;
    end else begin
      occ  <= occ_next;
      done <= fin;
      if (cfg_we) begin
        cap <= clamp_cap(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= rsp_next;
    end
    case (cmd)
      CMD_ACCEPT: begin
        cur <= req;
        if (req.req_type == REQ_POP) begin
          ptr <= PTR_W'(occ_m1);
        end else if (req.req_type == REQ_MOVE) begin
          ptr <= PTR_W'(req.index);
        end else begin
          ptr <= '0;
        end
      end
      CMD_PUSH: entries[occ[IDX_W-1:0]] <= cur.value;
      CMD_GRAB: begin
        hold <= rd_word;
        ptr  <= ptr + PTR_W'(1);
      end
      CMD_SHIFT: begin
        entries[ptr_m1[IDX_W-1:0]] <= rd_word;
        ptr <= ptr + PTR_W'(1);
      end
      CMD_FIN_MOVE: entries[occ_m1[IDX_W-1:0]] <= hold;
      CMD_NEXT: ptr <= ptr + PTR_W'(1);
      default: ;
    endcase
  end

endmodule

FILE: rtl/lru_stack_engine.sv
// Stack engine for least-recently-used ordering. A request beat is taken when start is high
// and busy is low; its result appears for one cycle under done, and the next beat can be taken
// in that cycle. Push, pop and any refused request other than find end after the decode step;
// pop bottom and move to top then shift one entry per step; find scans upwards one entry per
// step until the first match or the occupancy. The receiver cannot stall.
// Synchronous reset empties the stack and sets the capacity to its maximum.
module lru_stack_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  lse_pkg::req_t             req,
  output logic                      done,
  output lse_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [lse_pkg::CAP_W-1:0] cfg_data
);
  import lse_pkg::*;

  cmd_t    cmd;
  status_t status;

  lse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lse_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (status),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

FILE: rtl/lse_checker.sv
// Port-level checker for the stack engine, bound to the top level.
// Depends on lse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lse_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input lse_pkg::rsp_t rsp
);
  import lse_pkg::*;

  `CHK_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `CHK_ASSERT(a_busy_origin, clk, rst, $rose(busy) |-> $past(start), "busy rose without a request")
  `CHK_NEVER(a_done_busy, clk, rst, done && busy, "result beat while still busy")
  `CHK_NEVER(a_empty_full, clk, rst, done && rsp.is_empty && rsp.is_full, "empty and full at once")
  `CHK_ASSERT(a_fail_zero, clk, rst, (done && !rsp.ok) |-> (rsp.data_out == '0 && rsp.position == '0), "failed beat carries data")

endmodule

bind lru_stack_engine lse_checker u_lse_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

FILE: sim/lru_stack_engine_test.sv
// Self-checking testbench for the LRU stack engine: directed table, then random request beats.
// Depends on lse_pkg and lru_stack_engine; results are checked by fixed rows or a stack predictor.
module lru_stack_engine_test;
  import lse_pkg::*;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 80;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    req_t             rq;
    bit               fixed;
    rsp_t             want;
    logic [CAP_W-1:0] cap;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  logic signed [WORD_W-1:0] stk [DEPTH];
  int                       occ;
  int                       cap;
  rsp_t                     expected_rsp [$];
  bit                       row_fixed;
  rsp_t                     row_want;
  bit                       idle_on;
  int                       mismatch_cnt;
  int                       cycle_cnt;
  stim_row_t                dir_tab [$];
  logic signed [WORD_W-1:0] value_pool [8];

  lru_stack_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rsp_t lru_predict(req_t r);
    rsp_t                     o;
    logic signed [WORD_W-1:0] moved;
    int                       i;
    o = '0;
    case (r.req_type)
      REQ_PUSH: begin
        if (occ < cap) begin
          stk[occ] = r.value;
          o.position = 4'(occ);
          occ++;
          o.ok = 1'b1;
        end
      end
      REQ_POP: begin
        if (occ > 0) begin
          occ--;
          o.data_out = stk[occ];
          o.ok = 1'b1;
        end
      end
      REQ_POPB: begin
        if (occ > 0) begin
          o.data_out = stk[0];
          for (i = 0; i + 1 < occ; i++) stk[i] = stk[i + 1];
          occ--;
          o.ok = 1'b1;
        end
      end
      REQ_FIND: begin
        // Scanning downwards leaves the lowest matching position.
        for (i = occ - 1; i >= 0; i--) begin
          if (stk[i] == r.value) begin
            o.position = 4'(i);
            o.ok = 1'b1;
          end
        end
      end
      REQ_MOVE: begin
        if (int'(r.index) < occ) begin
          moved = stk[r.index];
          for (i = int'(r.index); i + 1 < occ; i++) stk[i] = stk[i + 1];
          stk[occ - 1] = moved;
          o.position = 4'(occ - 1);
          o.ok = 1'b1;
        end
      end
      default: ;
    endcase
    o.is_empty = (occ == 0);
    o.is_full = (occ >= cap);
    return o;
  endfunction

  task automatic check_rsp(rsp_t want, rsp_t got);
    if (got.ok !== want.ok) begin
      $display("%0t ok mismatch: expected %0b actual %0b", $time, want.ok, got.ok);
      mismatch_cnt++;
    end
    if (got.data_out !== want.data_out) begin
      $display("%0t data_out mismatch: expected %0h actual %0h", $time, want.data_out,
               got.data_out);
      mismatch_cnt++;
    end
    if (got.position !== want.position) begin
      $display("%0t position mismatch: expected %0d actual %0d", $time, want.position,
               got.position);
      mismatch_cnt++;
    end
    if (got.is_empty !== want.is_empty) begin
      $display("%0t is_empty mismatch: expected %0b actual %0b", $time, want.is_empty,
               got.is_empty);
      mismatch_cnt++;
    end
    if (got.is_full !== want.is_full) begin
      $display("%0t is_full mismatch: expected %0b actual %0b", $time, want.is_full,
               got.is_full);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    if (!rst) begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual %0h", $time, rsp);
          mismatch_cnt++;
        end else begin
          want = expected_rsp.pop_front();
          check_rsp(want, rsp);
        end
      end
      if (cfg_we) begin
        cap = (cfg_data == '0) ? 1 : ((int'(cfg_data) > DEPTH) ? DEPTH : int'(cfg_data));
        occ = 0;
      end
      if (start && !busy) begin
        pred = lru_predict(req);
        expected_rsp.push_back(row_fixed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic stim_row_t req_row(logic [2:0] t, logic signed [WORD_W-1:0] v,
                                        logic [IDX_W-1:0] ix);
    stim_row_t s;
    s.kind = ROW_REQ;
    s.rq = '{req_type: t, value: v, index: ix};
    s.fixed = 1'b0;
    s.want = '0;
    s.cap = '0;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(logic [2:0] t, logic signed [WORD_W-1:0] v,
                                          logic [IDX_W-1:0] ix, logic ok,
                                          logic signed [WORD_W-1:0] d, logic [IDX_W-1:0] p,
                                          logic emp, logic full);
    stim_row_t s;
    s = req_row(t, v, ix);
    s.fixed = 1'b1;
    s.want = '{ok: ok, data_out: d, position: p, is_empty: emp, is_full: full};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [CAP_W-1:0] c);
    stim_row_t s;
    s = req_row(REQ_PUSH, '0, '0);
    s.kind = ROW_CFG;
    s.cap = c;
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic issue_request(req_t r, bit fixed, rsp_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    start = 1'b1;
    req = r;
    row_fixed = fixed;
    row_want = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    start = 1'b0;
    while (expected_rsp.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = c;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic req_t random_request();
    req_t r;
    int   k;
    r.req_type = REQ_PUSH;
    r.value = $urandom();
    r.index = 4'($urandom_range(0, DEPTH - 1));
    k = $urandom_range(0, 99);
    if (k < 3) begin
      r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end else if (k < 40) begin
      if ($urandom_range(0, 1) == 0) r.value = value_pool[$urandom_range(0, 7)];
    end else if (k < 52) begin
      r.req_type = REQ_POP;
    end else if (k < 64) begin
      r.req_type = REQ_POPB;
    end else if (k < 82) begin
      r.req_type = REQ_FIND;
      if (occ > 0 && $urandom_range(0, 9) < 6) begin
        r.value = stk[$urandom_range(0, occ - 1)];
      end else if ($urandom_range(0, 1) == 0) begin
        r.value = value_pool[$urandom_range(0, 7)];
      end
    end else begin
      r.req_type = REQ_MOVE;
      if (occ > 0 && $urandom_range(0, 9) < 8) r.index = 4'($urandom_range(0, occ - 1));
    end
    return r;
  endfunction

  initial begin
    logic [CAP_W-1:0] phase_cap [10];
    int               p;
    int               n;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    occ = 0;
    cap = DEPTH;
    row_fixed = 1'b0;
    row_want = '0;
    idle_on = 1'b1;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    value_pool = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sd2, 32'sd3,
                   32'sh5a5a5a5a};

    dir_tab.push_back(fixed_row(REQ_POP, 32'sd9, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b1, 1'b0));
    dir_tab.push_back(fixed_row(REQ_POPB, 32'sd9, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b1, 1'b0));
    dir_tab.push_back(fixed_row(REQ_FIND, 32'sd0, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b1, 1'b0));
    dir_tab.push_back(fixed_row(REQ_MOVE, 32'sd0, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b1, 1'b0));
    dir_tab.push_back(fixed_row(REQ_UNUSED_HI, -32'sd1, 4'd15, 1'b0, 32'sd0, 4'd0, 1'b1,
                                1'b0));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sh7fffffff, 4'd15, 1'b1, 32'sd0, 4'd0, 1'b0,
                                1'b0));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sh80000000, 4'd0, 1'b1, 32'sd0, 4'd1, 1'b0,
                                1'b0));
    dir_tab.push_back(fixed_row(REQ_PUSH, -32'sd1, 4'd0, 1'b1, 32'sd0, 4'd2, 1'b0, 1'b0));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sd0, 4'd0, 1'b1, 32'sd0, 4'd3, 1'b0, 1'b0));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sh80000000, 4'd0, 1'b1, 32'sd0, 4'd4, 1'b0,
                                1'b0));
    dir_tab.push_back(fixed_row(REQ_FIND, 32'sh80000000, 4'd0, 1'b1, 32'sd0, 4'd1, 1'b0,
                                1'b0));
    dir_tab.push_back(fixed_row(REQ_FIND, 32'sd12345, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b0, 1'b0));
    dir_tab.push_back(fixed_row(REQ_MOVE, 32'sd0, 4'd15, 1'b0, 32'sd0, 4'd0, 1'b0, 1'b0));
    dir_tab.push_back(req_row(REQ_MOVE, 32'sd0, 4'd0));
    dir_tab.push_back(req_row(REQ_UNUSED_LO, 32'sh7fffffff, 4'd1));
    dir_tab.push_back(req_row(3'd6, 32'sh12345678, 4'd2));
    dir_tab.push_back(req_row(REQ_POP, 32'sd0, 4'd0));
    dir_tab.push_back(req_row(REQ_POPB, 32'sd0, 4'd0));
    dir_tab.push_back(req_row(REQ_FIND, -32'sd1, 4'd0));
    dir_tab.push_back(req_row(REQ_MOVE, 32'sd0, 4'd1));
    dir_tab.push_back(cfg_row(5'd0));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sha5a5a5a5, 4'd0, 1'b1, 32'sd0, 4'd0, 1'b0,
                                1'b1));
    dir_tab.push_back(fixed_row(REQ_PUSH, 32'sd1, 4'd0, 1'b0, 32'sd0, 4'd0, 1'b0, 1'b1));
    dir_tab.push_back(fixed_row(REQ_MOVE, 32'sd0, 4'd0, 1'b1, 32'sd0, 4'd0, 1'b0, 1'b1));
    dir_tab.push_back(fixed_row(REQ_POPB, 32'sd0, 4'd0, 1'b1, 32'sha5a5a5a5, 4'd0, 1'b1,
                                1'b0));
    dir_tab.push_back(cfg_row(5'd31));

    phase_cap = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'($urandom_range(1, 16)), 5'd1, 5'd17,
                  5'($urandom_range(1, 31)), 5'd16};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_capacity(dir_tab[i].cap);
      end else begin
        issue_request(dir_tab[i].rq, dir_tab[i].fixed, dir_tab[i].want);
      end
    end

    for (p = 0; p < 10; p++) begin
      write_capacity(phase_cap[p]);
      idle_on = (p < 8);
      for (n = 0; n < PHASE_ITEMS; n++) issue_request(random_request(), 1'b0, '0);
    end

    start = 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
